// ----- rtl/msds_pkg.sv -----
// shared types, field codes and defaults for the microcoded stack datapath
package msds_pkg;

	// default main memory size in bytes, a power of two
	localparam int unsigned MEM_BYTES_DEF = 4096;

	// step modes
	localparam logic [1:0] MODE_EXEC = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// bus b sources
	localparam logic [3:0] BSEL_MDR  = 4'd0;
	localparam logic [3:0] BSEL_PC   = 4'd1;
	localparam logic [3:0] BSEL_MBRU = 4'd2;
	localparam logic [3:0] BSEL_MBRS = 4'd3;
	localparam logic [3:0] BSEL_SP   = 4'd4;
	localparam logic [3:0] BSEL_LV   = 4'd5;
	localparam logic [3:0] BSEL_CPP  = 4'd6;
	localparam logic [3:0] BSEL_TOS  = 4'd7;
	localparam logic [3:0] BSEL_OPC  = 4'd8;

	// memory operations
	localparam logic [2:0] MEM_FETCH = 3'd1;
	localparam logic [2:0] MEM_RD    = 3'd2;
	localparam logic [2:0] MEM_WR    = 3'd4;

	// alu function codes
	localparam logic [5:0] ALU_AND     = 6'd12;
	localparam logic [5:0] ALU_ONE     = 6'd17;
	localparam logic [5:0] ALU_ONES    = 6'd18;
	localparam logic [5:0] ALU_B       = 6'd20;
	localparam logic [5:0] ALU_H       = 6'd24;
	localparam logic [5:0] ALU_NOT_H   = 6'd26;
	localparam logic [5:0] ALU_OR      = 6'd28;
	localparam logic [5:0] ALU_NOT_B   = 6'd44;
	localparam logic [5:0] ALU_B_INC   = 6'd53;
	localparam logic [5:0] ALU_B_DEC   = 6'd54;
	localparam logic [5:0] ALU_H_INC   = 6'd57;
	localparam logic [5:0] ALU_H_NEG   = 6'd59;
	localparam logic [5:0] ALU_ADD     = 6'd60;
	localparam logic [5:0] ALU_ADD_INC = 6'd61;
	localparam logic [5:0] ALU_B_SUB_H = 6'd63;

	// shifter codes
	localparam logic [1:0] SH_SRL1 = 2'd1;
	localparam logic [1:0] SH_SLL8 = 2'd2;

	// write mask bit positions
	localparam int unsigned WM_MAR = 0;
	localparam int unsigned WM_MDR = 1;
	localparam int unsigned WM_PC  = 2;
	localparam int unsigned WM_SP  = 3;
	localparam int unsigned WM_LV  = 4;
	localparam int unsigned WM_CPP = 5;
	localparam int unsigned WM_TOS = 6;
	localparam int unsigned WM_OPC = 7;
	localparam int unsigned WM_H   = 8;

	// microinstruction layout, msb first
	typedef struct packed {
		logic [8:0] next_addr;
		logic       jmpc;
		logic       jamn;
		logic       jamz;
		logic [1:0] shift;
		logic [5:0] alu;
		logic [8:0] mask;
		logic [2:0] memop;
		logic [3:0] bsel;
	} uword_t;

	// registers that can drive bus b
	typedef struct packed {
		logic [31:0] mdr;
		logic [31:0] pc;
		logic [7:0]  mbr;
		logic [31:0] sp;
		logic [31:0] lv;
		logic [31:0] cpp;
		logic [31:0] tos;
		logic [31:0] opc;
	} bsrc_t;

	// input item
	typedef struct packed {
		logic [1:0]  mode;
		logic [35:0] micro_word;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
	} item_t;

	// result item
	typedef struct packed {
		logic [8:0]  next_address;
		logic [7:0]  read_byte;
		logic [31:0] mar_value;
		logic [31:0] mdr_value;
		logic [31:0] pc_value;
		logic [7:0]  mbr_value;
		logic [31:0] sp_value;
		logic [31:0] lv_value;
		logic [31:0] cpp_value;
		logic [31:0] tos_value;
		logic [31:0] opc_value;
		logic [31:0] hold_value;
	} result_t;

	// what the second stage needs to finish a step
	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] memop;
		logic [1:0] lane;
		logic [8:0] next_addr;
		logic       jmpc;
		logic       jamn;
		logic       jamz;
		logic       zf;
		logic       nzf;
	} s2_t;

endpackage

// ----- rtl/microcoded_stack_datapath_step.sv -----
// top level: microinstruction pipeline, register file, memory lanes and result register
//
// Each accepted item runs one microinstruction (or one host byte load or read) and
// yields one result. The block accepts an item every cycle unless a held result or the
// clearing pass stalls it. Each item passes stage one, stage two and the result register:
// the first stage runs bus b, alu, shifter and the register writes and issues the
// memory access, the second stage takes the registered memory read data into MDR or
// MBR and forms the next address. A memory result of one step is forwarded to the step
// right behind it. Main memory is four byte lanes of MEM_BYTES/4 entries each
// (MEM_BYTES a power of two); after reset a clearing pass over every row zeroes it,
// during which no item is accepted. A stalled result holds the whole pipeline.
module microcoded_stack_datapath_step #(
	parameter int unsigned MEM_BYTES = msds_pkg::MEM_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  msds_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output msds_pkg::result_t result
);

	localparam int unsigned AW    = $clog2(MEM_BYTES);
	localparam int unsigned RW    = AW - 2;
	localparam int unsigned DEPTH = MEM_BYTES / 4;
	localparam logic [RW-1:0] ROW_LAST = RW'(DEPTH - 1);

	// pipeline and result registers
	logic              valid_s1;
	msds_pkg::item_t   item_s1;
	logic              valid_s2;
	msds_pkg::s2_t     info_s2;
	logic              result_valid_q;
	msds_pkg::result_t result_q;

	// architectural state
	logic [31:0] mar_q, mdr_q, pc_q, sp_q, lv_q, cpp_q, tos_q, opc_q, h_q, last_c_q;
	logic [7:0]  mbr_q;

	// clearing pass
	logic          clr_busy_q;
	logic [RW-1:0] clr_row_q;

	logic             en;
	logic             accept;
	msds_pkg::uword_t uw;
	logic             exec_s1;
	msds_pkg::bsrc_t  bsrc;
	logic [31:0]      c_bus;
	logic             zf, nzf;
	logic [31:0]      mdr_eff;
	logic [7:0]       mbr_eff;
	logic [31:0]      n_mar, n_mdr, n_pc, n_sp, n_lv, n_cpp, n_tos, n_opc, n_h;
	logic [31:0]      ld_ext;
	logic [1:0]       ld_lane;
	logic [RW-1:0]    lane_addr;
	logic [3:0]       lane_we;
	logic [7:0]       lane_wd [4];
	logic [7:0]       lane_rd [4];
	logic [31:0]      rd_word;
	logic             pend_word, pend_fetch;
	logic [8:0]       next_addr;
	logic [7:0]       read_byte;

	// pipeline advances unless a finished result is held back
	assign en         = !result_valid_q || !result_stall;
	assign item_stall = !en || clr_busy_q;
	assign accept     = item_valid && !item_stall;

	assign uw      = msds_pkg::uword_t'(item_s1.micro_word);
	assign exec_s1 = valid_s1 && (item_s1.mode == msds_pkg::MODE_EXEC);

	// forward memory read data of the step in stage two
	assign rd_word    = {lane_rd[3], lane_rd[2], lane_rd[1], lane_rd[0]};
	assign pend_word  = valid_s2 && (info_s2.mode == msds_pkg::MODE_EXEC)
		&& (info_s2.memop == msds_pkg::MEM_RD);
	assign pend_fetch = valid_s2 && (info_s2.mode == msds_pkg::MODE_EXEC)
		&& (info_s2.memop == msds_pkg::MEM_FETCH);
	assign mdr_eff    = pend_word ? rd_word : mdr_q;
	assign mbr_eff    = pend_fetch ? lane_rd[info_s2.lane] : mbr_q;

	// bus b sources
	always_comb begin
		bsrc.mdr = mdr_eff;
		bsrc.pc  = pc_q;
		bsrc.mbr = mbr_eff;
		bsrc.sp  = sp_q;
		bsrc.lv  = lv_q;
		bsrc.cpp = cpp_q;
		bsrc.tos = tos_q;
		bsrc.opc = opc_q;
	end

	msds_alu u_alu (
		.uw     (uw),
		.bsrc   (bsrc),
		.h      (h_q),
		.last_c (last_c_q),
		.c_bus  (c_bus),
		.zf     (zf),
		.nzf    (nzf)
	);

	// c bus write mask
	assign n_mar = uw.mask[msds_pkg::WM_MAR] ? c_bus : mar_q;
	assign n_mdr = uw.mask[msds_pkg::WM_MDR] ? c_bus : mdr_eff;
	assign n_pc  = uw.mask[msds_pkg::WM_PC]  ? c_bus : pc_q;
	assign n_sp  = uw.mask[msds_pkg::WM_SP]  ? c_bus : sp_q;
	assign n_lv  = uw.mask[msds_pkg::WM_LV]  ? c_bus : lv_q;
	assign n_cpp = uw.mask[msds_pkg::WM_CPP] ? c_bus : cpp_q;
	assign n_tos = uw.mask[msds_pkg::WM_TOS] ? c_bus : tos_q;
	assign n_opc = uw.mask[msds_pkg::WM_OPC] ? c_bus : opc_q;
	assign n_h   = uw.mask[msds_pkg::WM_H]   ? c_bus : h_q;

	// host byte address, wrapped to the memory size
	assign ld_ext  = 32'(item_s1.load_address);
	assign ld_lane = ld_ext[1:0];

	// memory lane address, one row shared by all lanes
	always_comb begin
		priority if (clr_busy_q) begin
			lane_addr = clr_row_q;
		end else if (exec_s1 && (uw.memop == msds_pkg::MEM_FETCH)) begin
			lane_addr = n_pc[AW-1:2];
		end else if (exec_s1) begin
			lane_addr = n_mar[RW-1:0];
		end else begin
			lane_addr = ld_ext[AW-1:2];
		end
	end

	// memory lanes, little-endian word at mar*4
	for (genvar i = 0; i < 4; i++) begin : g_lane
		always_comb begin
			priority if (clr_busy_q) begin
				lane_we[i] = 1'b1;
				lane_wd[i] = 8'd0;
			end else if (exec_s1) begin
				lane_we[i] = en && (uw.memop == msds_pkg::MEM_WR);
				lane_wd[i] = n_mdr[8*i +: 8];
			end else begin
				lane_we[i] = en && valid_s1 && (item_s1.mode == msds_pkg::MODE_LOAD)
					&& (ld_lane == 2'(i));
				lane_wd[i] = item_s1.load_byte;
			end
		end

		msds_lane #(
			.DEPTH (DEPTH),
			.RW    (RW)
		) u_lane (
			.clk  (clk),
			.re   (en && !clr_busy_q),
			.we   (lane_we[i]),
			.addr (lane_addr),
			.wd   (lane_wd[i]),
			.rd   (lane_rd[i])
		);
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == ROW_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// register file, committed in stage one, memory data absorbed from stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mar_q    <= '0;
			mdr_q    <= '0;
			pc_q     <= '0;
			mbr_q    <= '0;
			sp_q     <= '0;
			lv_q     <= '0;
			cpp_q    <= '0;
			tos_q    <= '0;
			opc_q    <= '0;
			h_q      <= '0;
			last_c_q <= '0;
		end else if (en) begin
			mbr_q <= mbr_eff;
			mdr_q <= exec_s1 ? n_mdr : mdr_eff;
			if (exec_s1) begin
				mar_q    <= n_mar;
				pc_q     <= n_pc;
				sp_q     <= n_sp;
				lv_q     <= n_lv;
				cpp_q    <= n_cpp;
				tos_q    <= n_tos;
				opc_q    <= n_opc;
				h_q      <= n_h;
				last_c_q <= c_bus;
			end
		end
	end

	// pipeline valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1       <= accept;
			valid_s2       <= valid_s1;
			result_valid_q <= valid_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1           <= item;
			info_s2.mode      <= item_s1.mode;
			info_s2.memop     <= uw.memop;
			info_s2.lane      <= (item_s1.mode == msds_pkg::MODE_EXEC) ? n_pc[1:0] : ld_lane;
			info_s2.next_addr <= uw.next_addr;
			info_s2.jmpc      <= uw.jmpc;
			info_s2.jamn      <= uw.jamn;
			info_s2.jamz      <= uw.jamz;
			info_s2.zf        <= zf;
			info_s2.nzf       <= nzf;
		end
	end

	// next address and host read byte
	always_comb begin
		if (info_s2.mode == msds_pkg::MODE_EXEC) begin
			next_addr = info_s2.next_addr
				| {(info_s2.jamz && info_s2.zf) || (info_s2.jamn && info_s2.nzf), 8'd0}
				| (info_s2.jmpc ? {1'b0, mbr_eff} : 9'd0);
		end else begin
			next_addr = '0;
		end
		read_byte = (info_s2.mode == msds_pkg::MODE_READ) ? lane_rd[info_s2.lane] : 8'd0;
	end

	// result register
	always_ff @(posedge clk) begin
		if (en) begin
			result_q.next_address <= next_addr;
			result_q.read_byte    <= read_byte;
			result_q.mar_value    <= mar_q;
			result_q.mdr_value    <= mdr_eff;
			result_q.pc_value     <= pc_q;
			result_q.mbr_value    <= mbr_eff;
			result_q.sp_value     <= sp_q;
			result_q.lv_value     <= lv_q;
			result_q.cpp_value    <= cpp_q;
			result_q.tos_value    <= tos_q;
			result_q.opc_value    <= opc_q;
			result_q.hold_value   <= h_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// pipeline stays empty while memory is being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!valid_s1 && !valid_s2 && !result_valid_q))
		else $error("item in flight during memory clear");

	// memory is written only by the clearing pass or an advancing step
	a_write_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_we != 4'd0) |-> (clr_busy_q || (en && valid_s1)))
		else $error("memory write without an advancing step");

	// a held result freezes the second stage
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> ($stable(valid_s2) && $stable(info_s2)))
		else $error("second stage moved while result stalled");

	// flags of an executed step are complementary
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (info_s2.mode == msds_pkg::MODE_EXEC)) |-> (info_s2.zf != info_s2.nzf))
		else $error("zero and nonzero flags agree");

	// a step that advances out of stage one is in stage two in the following cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s1) |=> valid_s2)
		else $error("step lost between stages");
`endif

endmodule

// ----- rtl/msds_lane.sv -----
// one byte lane of main memory with a registered read port
module msds_lane #(
	parameter int unsigned DEPTH = msds_pkg::MEM_BYTES_DEF / 4,
	parameter int unsigned RW    = $clog2(msds_pkg::MEM_BYTES_DEF / 4)
) (
	input  logic          clk,
	input  logic          re,
	input  logic          we,
	input  logic [RW-1:0] addr,
	input  logic [7:0]    wd,
	output logic [7:0]    rd
);

	logic [7:0] mem [DEPTH];

	// single port, old data on a read that meets a write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wd;
		end
		if (re) begin
			rd <= mem[addr];
		end
	end

endmodule

// ----- rtl/msds_alu.sv -----
// bus b selection, alu, flags and shifter for one microinstruction
module msds_alu (
	input  msds_pkg::uword_t uw,
	input  msds_pkg::bsrc_t  bsrc,
	input  logic [31:0]      h,
	input  logic [31:0]      last_c,
	output logic [31:0]      c_bus,
	output logic             zf,
	output logic             nzf
);

	logic [31:0] b_bus;
	logic [31:0] alu_out;

	// bus b driver, unused selects give all ones
	always_comb begin
		unique case (uw.bsel)
			msds_pkg::BSEL_MDR:  b_bus = bsrc.mdr;
			msds_pkg::BSEL_PC:   b_bus = bsrc.pc;
			msds_pkg::BSEL_MBRU: b_bus = {24'd0, bsrc.mbr};
			msds_pkg::BSEL_MBRS: b_bus = {{24{bsrc.mbr[7]}}, bsrc.mbr};
			msds_pkg::BSEL_SP:   b_bus = bsrc.sp;
			msds_pkg::BSEL_LV:   b_bus = bsrc.lv;
			msds_pkg::BSEL_CPP:  b_bus = bsrc.cpp;
			msds_pkg::BSEL_TOS:  b_bus = bsrc.tos;
			msds_pkg::BSEL_OPC:  b_bus = bsrc.opc;
			default:             b_bus = '1;
		endcase
	end

	// alu, an unknown code repeats the previous c bus
	always_comb begin
		unique case (uw.alu)
			msds_pkg::ALU_AND:     alu_out = h & b_bus;
			msds_pkg::ALU_ONE:     alu_out = 32'd1;
			msds_pkg::ALU_ONES:    alu_out = '1;
			msds_pkg::ALU_B:       alu_out = b_bus;
			msds_pkg::ALU_H:       alu_out = h;
			msds_pkg::ALU_NOT_H:   alu_out = ~h;
			msds_pkg::ALU_OR:      alu_out = h | b_bus;
			msds_pkg::ALU_NOT_B:   alu_out = ~b_bus;
			msds_pkg::ALU_B_INC:   alu_out = b_bus + 32'd1;
			msds_pkg::ALU_B_DEC:   alu_out = b_bus - 32'd1;
			msds_pkg::ALU_H_INC:   alu_out = h + 32'd1;
			msds_pkg::ALU_H_NEG:   alu_out = 32'd0 - h;
			msds_pkg::ALU_ADD:     alu_out = h + b_bus;
			msds_pkg::ALU_ADD_INC: alu_out = h + b_bus + 32'd1;
			msds_pkg::ALU_B_SUB_H: alu_out = b_bus - h;
			default:               alu_out = last_c;
		endcase
	end

	// flags come from the unshifted result
	assign zf  = (alu_out == 32'd0);
	assign nzf = (alu_out != 32'd0);

	// shifter
	always_comb begin
		unique case (uw.shift)
			msds_pkg::SH_SRL1: c_bus = {1'b0, alu_out[31:1]};
			msds_pkg::SH_SLL8: c_bus = {alu_out[23:0], 8'd0};
			default:           c_bus = alu_out;
		endcase
	end

endmodule

// ----- tb/tb.sv -----
// testbench for microcoded_stack_datapath_step: directed table then random steps, checked against a local predictor
module tb;
	import msds_pkg::*;

	localparam int unsigned MEM_SIZE = MEM_BYTES_DEF;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [2:0] MEM_NONE = 3'd0;
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_BOTH = 2'd3;
	localparam logic [2:0] JAM_NONE = 3'b000;
	localparam logic [2:0] JAM_Z = 3'b001;
	localparam logic [2:0] JAM_N = 3'b010;
	localparam logic [2:0] JAM_C = 3'b100;
	localparam logic [5:0] ALU_UNLISTED = 6'd0;
	localparam logic [8:0] MASK_NONE = 9'd0;
	localparam logic [8:0] MASK_ALL = 9'h1FF;
	localparam logic [5:0] ALU_CODES [15] = '{ALU_AND, ALU_ONE, ALU_ONES, ALU_B, ALU_H,
		ALU_NOT_H, ALU_OR, ALU_NOT_B, ALU_B_INC, ALU_B_DEC, ALU_H_INC, ALU_H_NEG, ALU_ADD,
		ALU_ADD_INC, ALU_B_SUB_H};
	localparam int RANDOM_STEPS = 525;
	localparam int MAX_GAP = 18;
	localparam int LONG_HOLD = 100;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// predictor state
	logic [31:0] mar, mdr, pc, sp, lv, cpp, tos, opc, hreg, last_c;
	logic [7:0]  mbr;
	logic        zf, nzf;
	logic [7:0]  mem [MEM_SIZE];

	result_t pending_results [$];
	row_t    script [$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      idle_cycles = 0;
	bit      long_hold_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	microcoded_stack_datapath_step dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// one step of the datapath: bus b, alu, shifter, register writes, memory, next address
	task automatic run_datapath_step(input item_t it, output result_t r);
		uword_t      u;
		logic [31:0] b, c;
		logic [33:0] base;
		logic [8:0]  nxt;
		logic [7:0]  rbyte;
		int          i;
		u = it.micro_word;
		nxt = '0;
		rbyte = '0;
		case (it.mode)
			MODE_EXEC: begin
				case (u.bsel)
					BSEL_MDR:  b = mdr;
					BSEL_PC:   b = pc;
					BSEL_MBRU: b = {24'd0, mbr};
					BSEL_MBRS: b = {{24{mbr[7]}}, mbr};
					BSEL_SP:   b = sp;
					BSEL_LV:   b = lv;
					BSEL_CPP:  b = cpp;
					BSEL_TOS:  b = tos;
					BSEL_OPC:  b = opc;
					default:   b = '1;
				endcase
				case (u.alu)
					ALU_AND:     c = hreg & b;
					ALU_ONE:     c = 32'd1;
					ALU_ONES:    c = '1;
					ALU_B:       c = b;
					ALU_H:       c = hreg;
					ALU_NOT_H:   c = ~hreg;
					ALU_OR:      c = hreg | b;
					ALU_NOT_B:   c = ~b;
					ALU_B_INC:   c = b + 32'd1;
					ALU_B_DEC:   c = b - 32'd1;
					ALU_H_INC:   c = hreg + 32'd1;
					ALU_H_NEG:   c = 32'd0 - hreg;
					ALU_ADD:     c = hreg + b;
					ALU_ADD_INC: c = hreg + b + 32'd1;
					ALU_B_SUB_H: c = b - hreg;
					default:     c = last_c;
				endcase
				// flags come from the alu output, before the shifter
				zf = (c == 32'd0);
				nzf = (c != 32'd0);
				if (u.shift == SH_SRL1)
					c = c >> 1;
				else if (u.shift == SH_SLL8)
					c = c << 8;
				last_c = c;
				if (u.mask[WM_MAR]) mar = c;
				if (u.mask[WM_MDR]) mdr = c;
				if (u.mask[WM_PC])  pc = c;
				if (u.mask[WM_SP])  sp = c;
				if (u.mask[WM_LV])  lv = c;
				if (u.mask[WM_CPP]) cpp = c;
				if (u.mask[WM_TOS]) tos = c;
				if (u.mask[WM_OPC]) opc = c;
				if (u.mask[WM_H])   hreg = c;
				// memory sees the freshly written registers; words are little-endian
				base = {mar, 2'b00};
				case (u.memop)
					MEM_FETCH: mbr = mem[pc % MEM_SIZE];
					MEM_RD: begin
						for (i = 0; i < 4; i++)
							mdr[8*i +: 8] = mem[(base + i) % MEM_SIZE];
					end
					MEM_WR: begin
						for (i = 0; i < 4; i++)
							mem[(base + i) % MEM_SIZE] = mdr[8*i +: 8];
					end
					default: ;
				endcase
				nxt = u.next_addr;
				if (u.jamz) nxt[8] = nxt[8] | zf;
				if (u.jamn) nxt[8] = nxt[8] | nzf;
				if (u.jmpc) nxt = nxt | {1'b0, mbr};
			end
			MODE_LOAD: mem[it.load_address % MEM_SIZE] = it.load_byte;
			MODE_READ: rbyte = mem[it.load_address % MEM_SIZE];
			default: ;
		endcase
		r = '{next_address: nxt, read_byte: rbyte, mar_value: mar, mdr_value: mdr,
			pc_value: pc, mbr_value: mbr, sp_value: sp, lv_value: lv, cpp_value: cpp,
			tos_value: tos, opc_value: opc, hold_value: hreg};
	endtask

	function automatic item_t exec_step(logic [8:0] nxt, logic [2:0] jam, logic [1:0] sh,
			logic [5:0] alu, logic [8:0] mask, logic [2:0] memop, logic [3:0] bsel);
		uword_t u;
		item_t  it;
		u = '{next_addr: nxt, jmpc: jam[2], jamn: jam[1], jamz: jam[0], shift: sh,
			alu: alu, mask: mask, memop: memop, bsel: bsel};
		it = '0;
		it.mode = MODE_EXEC;
		it.micro_word = u;
		return it;
	endfunction

	function automatic item_t host_step(logic [1:0] mode, logic [11:0] addr, logic [7:0] data);
		item_t it;
		it = '0;
		it.mode = mode;
		it.load_address = addr;
		it.load_byte = data;
		return it;
	endfunction

	// mostly well-formed microinstructions, plus host byte traffic and raw noise
	function automatic item_t random_step();
		item_t      it;
		int         pick;
		logic [5:0] alu;
		logic [2:0] memop;
		logic [3:0] bsel;
		pick = $urandom_range(0, 99);
		it.mode = MODE_EXEC;
		it.micro_word = 36'({$urandom(), $urandom()});
		it.load_address = 12'($urandom());
		it.load_byte = 8'($urandom());
		if (pick < 8) begin
			it.mode = MODE_LOAD;
			if ($urandom_range(0, 1) == 0)
				it.load_address = 12'($urandom_range(0, 63));
		end else if (pick < 14) begin
			it.mode = MODE_READ;
			if ($urandom_range(0, 1) == 0)
				it.load_address = 12'($urandom_range(0, 63));
		end else if (pick < 16) begin
			it.mode = MODE_NONE;
		end else if (pick < 30 && pick >= 22) begin
			// small mar and pc so that memory traffic lands on loaded bytes
			case ($urandom_range(0, 2))
				0:       memop = MEM_FETCH;
				1:       memop = MEM_RD;
				default: memop = MEM_WR;
			endcase
			it = exec_step(9'($urandom()), 3'($urandom()), 2'($urandom()), ALU_ONE,
				(9'd1 << WM_MAR) | (9'd1 << WM_PC) | 9'($urandom() & 32'h1F8), memop,
				4'($urandom_range(0, 15)));
		end else if (pick >= 30) begin
			alu = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : ALU_CODES[$urandom_range(0, 14)];
			case ($urandom_range(0, 9))
				0, 1, 2, 3: memop = MEM_NONE;
				4:          memop = MEM_FETCH;
				5:          memop = MEM_RD;
				6:          memop = MEM_WR;
				default:    memop = 3'($urandom());
			endcase
			bsel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			it = exec_step(9'($urandom()), 3'($urandom()), 2'($urandom()), alu, 9'($urandom()),
				memop, bsel);
		end
		return it;
	endfunction

	// bursts of back-to-back transfers alternate with random gaps
	function automatic int draw_gap(int idx);
		return ((idx / 40) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// offer one item, predict it once the transfer happens
	task automatic send_step(input item_t it, input bit typed, input result_t want, input int gap);
		result_t r;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		run_datapath_step(it, r);
		pending_results.push_back(typed ? want : r);
	endtask

	// stop offering until every expected result is back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no expected result pending");
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			cmp_field("next_address", want.next_address, got.next_address);
			cmp_field("read_byte", want.read_byte, got.read_byte);
			cmp_field("mar_value", want.mar_value, got.mar_value);
			cmp_field("mdr_value", want.mdr_value, got.mdr_value);
			cmp_field("pc_value", want.pc_value, got.pc_value);
			cmp_field("mbr_value", want.mbr_value, got.mbr_value);
			cmp_field("sp_value", want.sp_value, got.sp_value);
			cmp_field("lv_value", want.lv_value, got.lv_value);
			cmp_field("cpp_value", want.cpp_value, got.cpp_value);
			cmp_field("tos_value", want.tos_value, got.tos_value);
			cmp_field("opc_value", want.opc_value, got.opc_value);
			cmp_field("hold_value", want.hold_value, got.hold_value);
		end
	endtask

	// result side: random stalls, one long hold-off to back up the pipeline
	initial begin
		int gap;
		forever begin
			gap = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
			if (results_seen == 120 && !long_hold_done) begin
				gap = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
			check_result(result);
			results_seen++;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin
		result_t zero_state, ones_state, unused;
		int      k;
		mar = '0; mdr = '0; pc = '0; sp = '0; lv = '0; cpp = '0; tos = '0; opc = '0;
		hreg = '0; last_c = '0; mbr = '0; zf = 1'b0; nzf = 1'b0;
		for (k = 0; k < MEM_SIZE; k++)
			mem[k] = 8'd0;
		zero_state = '0;
		ones_state = '1;
		ones_state.read_byte = '0;
		ones_state.mbr_value = '0;
		unused = '0;

		// directed table: reset state, every alu code, shifts, jams, memory ops, wrap
		script.push_back('{host_step(MODE_READ, 12'h000, 8'h00), 1'b1, zero_state});
		script.push_back('{host_step(MODE_NONE, 12'hFFF, 8'hFF), 1'b1, zero_state});
		script.push_back('{exec_step(9'h1FF, JAM_NONE, SH_NONE, ALU_ONES, MASK_ALL, MEM_NONE,
			BSEL_MDR), 1'b1, ones_state});
		script.push_back('{host_step(MODE_LOAD, 12'hFFF, 8'hFF), 1'b0, unused});
		script.push_back('{host_step(MODE_LOAD, 12'hFFC, 8'h80), 1'b0, unused});
		// mar of all ones wraps to the top word of memory
		script.push_back('{exec_step(9'h000, JAM_NONE, SH_NONE, ALU_H, MASK_NONE, MEM_RD, 4'd15),
			1'b0, unused});
		script.push_back('{exec_step(9'h100, JAM_C, SH_NONE, ALU_AND, MASK_NONE, MEM_FETCH,
			4'd9), 1'b0, unused});
		script.push_back('{exec_step(9'h0AA, JAM_NONE, SH_BOTH, ALU_B, 9'd1 << WM_TOS, MEM_NONE,
			BSEL_MBRS), 1'b0, unused});
		script.push_back('{exec_step(9'h155, JAM_NONE, SH_NONE, ALU_ONE,
			(9'd1 << WM_H) | (9'd1 << WM_MAR), MEM_NONE, BSEL_MBRU), 1'b0, unused});
		script.push_back('{exec_step(9'h001, JAM_NONE, SH_SRL1, ALU_OR, 9'd1 << WM_OPC, MEM_NONE,
			BSEL_MBRU), 1'b0, unused});
		script.push_back('{exec_step(9'h002, JAM_N, SH_NONE, ALU_NOT_H, 9'd1 << WM_SP, MEM_NONE,
			BSEL_MDR), 1'b0, unused});
		script.push_back('{exec_step(9'h004, JAM_NONE, SH_SLL8, ALU_NOT_B, 9'd1 << WM_LV,
			MEM_NONE, BSEL_PC), 1'b0, unused});
		script.push_back('{exec_step(9'h008, JAM_Z, SH_NONE, ALU_B_INC, 9'd1 << WM_CPP, MEM_NONE,
			BSEL_TOS), 1'b0, unused});
		script.push_back('{exec_step(9'h010, JAM_Z | JAM_N, SH_NONE, ALU_B_DEC, 9'd1 << WM_MDR,
			MEM_NONE, BSEL_CPP), 1'b0, unused});
		script.push_back('{exec_step(9'h020, JAM_NONE, SH_NONE, ALU_H_INC, 9'd1 << WM_H, MEM_WR,
			BSEL_SP), 1'b0, unused});
		// memory op codes outside fetch, read and write touch nothing
		script.push_back('{exec_step(9'h040, JAM_NONE, SH_NONE, ALU_H_NEG, 9'd1 << WM_OPC, 3'd3,
			BSEL_LV), 1'b0, unused});
		script.push_back('{exec_step(9'h080, JAM_NONE, SH_NONE, ALU_ADD, MASK_NONE, 3'd5,
			BSEL_OPC), 1'b0, unused});
		script.push_back('{exec_step(9'h0FF, JAM_NONE, SH_NONE, ALU_ADD_INC, 9'd1 << WM_TOS, 3'd6,
			BSEL_SP), 1'b0, unused});
		script.push_back('{exec_step(9'h1FE, JAM_NONE, SH_NONE, ALU_B_SUB_H, 9'd1 << WM_PC, 3'd7,
			BSEL_LV), 1'b0, unused});
		// unlisted alu code reuses the previous c bus
		script.push_back('{exec_step(9'h000, JAM_NONE, SH_SLL8, ALU_UNLISTED, 9'd1 << WM_SP,
			MEM_NONE, BSEL_MDR), 1'b0, unused});
		script.push_back('{exec_step(9'h003, JAM_Z, SH_NONE, 6'd1, MASK_NONE, MEM_RD, 4'd12),
			1'b0, unused});
		script.push_back('{host_step(MODE_READ, 12'h004, 8'h00), 1'b0, unused});
		script.push_back('{host_step(MODE_READ, 12'hFFF, 8'h00), 1'b0, unused});
		script.push_back('{exec_step(9'h000, JAM_NONE, SH_NONE, ALU_UNLISTED, MASK_NONE, MEM_NONE,
			BSEL_MDR), 1'b0, unused});
		script.push_back('{exec_step(9'h1FF, 3'b111, SH_BOTH, ALU_B_SUB_H, MASK_ALL, 3'd7, 4'd15),
			1'b0, unused});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_step(script[i].stim, script[i].typed, script[i].want, draw_gap(i));
		drain_results();

		for (k = 0; k < RANDOM_STEPS; k++) begin
			send_step(random_step(), 1'b0, unused, draw_gap(k));
			if (k == 275)
				drain_results();
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
